// ===== hw/rtl/bloom_filter_add_query_assert.svh =====
// assertion macros for the bloom filter block
`ifndef BLOOM_FILTER_ADD_QUERY_ASSERT_SVH
`define BLOOM_FILTER_ADD_QUERY_ASSERT_SVH
`ifndef SYNTHESIS
`define BFAQ_ASSERT(label, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");
`define BFAQ_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`else
`define BFAQ_ASSERT(label, cond)
`define BFAQ_IMPLY(label, ante, cons)
`endif
`endif

// ===== hw/rtl/bfaq_pkg.sv =====
// shared types and constants for the bloom filter block
package bfaq_pkg;
    localparam logic [63:0] MM_C1 = 64'h87c37b91114253d5;
    localparam logic [63:0] MM_C2 = 64'h4cf5ad432745937f;
    localparam logic [63:0] FMIX_M1 = 64'hff51afd7ed558ccd;
    localparam logic [63:0] FMIX_M2 = 64'hc4ceb9fe1a85ec53;
    localparam logic CMD_ADD = 1'b0;
    localparam logic CMD_QUERY = 1'b1;
    localparam logic CFG_FILTER_SIZE = 1'b0;
    localparam logic CFG_NUM_HASHES = 1'b1;

    typedef enum logic [5:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_B1A, ST_B1B, ST_B1C, ST_B1D,
        ST_B2A, ST_B2B, ST_B2C, ST_B2D,
        ST_BMIX1, ST_BMIX1W, ST_BMIX2, ST_BMIX2W,
        ST_T2A, ST_T2B, ST_T2C, ST_T2D,
        ST_T1A, ST_T1B, ST_T1C, ST_T1D,
        ST_FIN0,
        ST_F1A, ST_F1B, ST_F1C, ST_F1D,
        ST_F2A, ST_F2B, ST_F2C, ST_F2D,
        ST_FIN1,
        ST_PROBE, ST_PMUL, ST_PMOD, ST_PMODW,
        ST_PREAD, ST_PWAIT, ST_PCHK,
        ST_RESULT
    } state_t;

    typedef struct packed {
        logic start;
    } mul_ctl_t;

    function automatic logic [63:0] rotl64(input logic [63:0] x, input logic [5:0] r);
        logic [127:0] d;
        d = {x, x} << r;
        return d[127:64];
    endfunction
endpackage

// ===== hw/rtl/bfaq_ram.sv =====
// generic single-port ram with registered read
module bfaq_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] addr,
    input  logic [WIDTH-1:0]         wdata,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule

// ===== hw/rtl/bfaq_mul.sv =====
// shared 64x64 modular multiplier, three 32x32 partial products over cycles
module bfaq_mul (
    input  logic              clk,
    input  logic              rst_n,
    input  bfaq_pkg::mul_ctl_t ctl_in,
    input  logic [63:0]       a,
    input  logic [63:0]       b,
    output logic [63:0]       p,
    output logic              done
);
    import bfaq_pkg::*;

    logic [2:0]  step_reg, step_next;
    logic [63:0] acc_reg, acc_next;
    logic [63:0] pp_reg;
    logic [31:0] ma, mb;

    always_comb
    begin
        case (step_reg)
            3'd1:    begin ma = a[31:0];  mb = b[31:0];  end
            3'd2:    begin ma = a[63:32]; mb = b[31:0];  end
            3'd3:    begin ma = a[31:0];  mb = b[63:32]; end
            default: begin ma = a[31:0];  mb = b[31:0];  end
        endcase
    end

    always_ff @(posedge clk)
    begin
        pp_reg <= ma * mb;
    end

    always_comb
    begin
        step_next = step_reg;
        acc_next = acc_reg;
        if (ctl_in.start)
        begin
            step_next = 3'd1;
            acc_next = '0;
        end
        else if (step_reg != 3'd0)
        begin
            step_next = (step_reg == 3'd4) ? 3'd0 : step_reg + 3'd1;
            case (step_reg)
                3'd2:    acc_next = pp_reg;
                3'd3:    acc_next = acc_reg + {pp_reg[31:0], 32'd0};
                3'd4:    acc_next = acc_reg + {pp_reg[31:0], 32'd0};
                default: acc_next = acc_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= 3'd0;
            acc_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
            acc_reg <= acc_next;
        end
    end

    logic done_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= (step_reg == 3'd4);
        end
    end

    assign p = acc_reg;
    assign done = done_reg;
endmodule

// ===== hw/rtl/bloom_filter_add_query.sv =====
// Bloom filter engine: keys stream in one byte per item and are hashed with
// MurmurHash3 x64/128 (seed 0); the last byte triggers num_hashes probes at
// (h1 + n*h2) mod filter_size. Every multiply by a hash constant runs through
// one shared multiplier and each probe index through a bit-serial remainder
// unit. An ordinary byte is taken back to back with the next; a byte closing a
// 16-byte block holds off the input while the block is mixed; a last byte
// holds it off while the tail and finalization are hashed (a last byte that
// also closes a block mixes that block first) and while its probes run, an
// add setting each probed bit and a query stopping at the first clear bit,
// until its result item. No item is taken while a result item waits. After
// reset a clearing pass zeroes every bit of the store before the first item
// is taken.
module bloom_filter_add_query #(
    parameter int FILTER_BITS = 65536,
    parameter int MAX_PROBES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // key_byte
    input  logic        s_tuser,   // command
    input  logic        s_tlast,   // last_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [0] was_query, [1] possibly_present
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [16:0] cfg_data
);
    import bfaq_pkg::*;
`include "bloom_filter_add_query_assert.svh"

    localparam int AW = $clog2(FILTER_BITS);
    localparam int PW = $clog2(MAX_PROBES + 1);
    localparam int SW = (AW + 1 > 17) ? AW + 1 : 17;

    state_t state_reg, state_next;
    logic [16:0] fsize_reg;
    logic [5:0]  nhash_reg;
    logic [63:0] hl_reg, hl_next, hh_reg, hh_next;
    logic [127:0] buf_reg, buf_next;
    logic [31:0] len_reg, len_next;
    logic [63:0] x_reg, x_next, y_reg, y_next;
    logic        cmd_reg, cmd_next, pres_reg, pres_next, last_reg, last_next;
    logic [5:0]  n_reg, n_next;
    logic [AW:0] clr_reg, clr_next;
    logic        ov_reg, ov_next;
    logic [1:0]  res_reg, res_next;
    // remainder unit
    logic [63:0]   dv_reg, dv_next;
    logic [SW-1:0] rm_reg, rm_next;
    logic [6:0]    bc_reg, bc_next;

    mul_ctl_t    mctl;
    logic [63:0] mp;
    logic        mdone;
    logic [63:0] mop_a, mop_b;

    bfaq_mul u_mul (
        .clk(clk), .rst_n(rst_n), .ctl_in(mctl),
        .a(mop_a), .b(mop_b), .p(mp), .done(mdone)
    );

    logic          ram_we, ram_wd, ram_rd;
    logic [AW-1:0] ram_addr;
    bfaq_ram #(.WIDTH(1), .DEPTH(FILTER_BITS)) u_ram (
        .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wd), .rdata(ram_rd)
    );

    logic [SW-1:0] size_eff;
    logic [PW-1:0] probes_eff;
    always_comb
    begin
        if (fsize_reg == 17'd0 || {15'd0, fsize_reg} > 32'(FILTER_BITS))
            size_eff = SW'(FILTER_BITS);
        else
            size_eff = SW'(fsize_reg);
        if ({26'd0, nhash_reg} > 32'(MAX_PROBES))
            probes_eff = PW'(MAX_PROBES);
        else
            probes_eff = PW'(nhash_reg);
    end

    logic [SW:0] rm_sh;
    assign rm_sh = {rm_reg, dv_reg[63]};

    assign cfg_ready = (state_reg == ST_IDLE) && !m_tvalid;
    assign s_tready = (state_reg == ST_IDLE) && !m_tvalid;
    assign m_tvalid = ov_reg;
    assign m_tdata = {6'd0, res_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fsize_reg <= 17'd65536;
            nhash_reg <= 6'd4;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_FILTER_SIZE)
                fsize_reg <= cfg_data;
            else
                nhash_reg <= cfg_data[5:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        hl_next = hl_reg; hh_next = hh_reg; buf_next = buf_reg; len_next = len_reg;
        x_next = x_reg; y_next = y_reg;
        cmd_next = cmd_reg; pres_next = pres_reg; last_next = last_reg;
        n_next = n_reg; clr_next = clr_reg; ov_next = ov_reg; res_next = res_reg;
        dv_next = dv_reg; rm_next = rm_reg; bc_next = bc_reg;
        mctl = '0; mop_a = x_reg; mop_b = MM_C1;
        ram_we = 1'b0; ram_wd = 1'b0; ram_addr = rm_reg[AW-1:0];
        if (ov_reg && m_tready)
            ov_next = 1'b0;
        case (state_reg)
            ST_CLEAR:
            begin
                ram_we = 1'b1;
                ram_addr = clr_reg[AW-1:0];
                clr_next = clr_reg + (AW+1)'(1);
                if (clr_reg == (AW+1)'(FILTER_BITS - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (s_tvalid && s_tready)
                begin
                    buf_next = buf_reg | (128'(s_tdata) << {len_reg[3:0], 3'd0});
                    len_next = len_reg + 32'd1;
                    cmd_next = s_tuser;
                    last_next = s_tlast;
                    if (len_reg[3:0] == 4'd15)
                    begin
                        x_next = (buf_next[63:0]);
                        state_next = ST_B1A;
                    end
                    else if (s_tlast)
                        state_next = ST_T2A;
                end
            end
            // k1 = rotl(k1*C1,31)*C2
            ST_B1A: begin mctl.start = 1'b1; state_next = ST_B1B; end
            ST_B1B: if (mdone) begin x_next = rotl64(mp, 6'd31); state_next = ST_B1C; end
            ST_B1C: begin mctl.start = 1'b1; mop_b = MM_C2; state_next = ST_B1D; end
            ST_B1D:
            begin
                mop_b = MM_C2;
                if (mdone)
                begin
                    hl_next = rotl64(hl_reg ^ mp, 6'd27) + hh_reg;
                    x_next = buf_reg[127:64];
                    state_next = ST_B2A;
                end
            end
            ST_B2A: begin mctl.start = 1'b1; mop_b = MM_C2; state_next = ST_B2B; end
            ST_B2B:
            begin
                mop_b = MM_C2;
                if (mdone) begin x_next = rotl64(mp, 6'd33); state_next = ST_B2C; end
            end
            ST_B2C: begin mctl.start = 1'b1; state_next = ST_B2D; end
            ST_B2D:
            begin
                if (mdone)
                begin
                    y_next = mp;
                    hl_next = hl_reg * 64'd5 + 64'h52dce729;
                    state_next = ST_BMIX1;
                end
            end
            ST_BMIX1:
            begin
                hh_next = rotl64(hh_reg ^ y_reg, 6'd31) + hl_reg;
                state_next = ST_BMIX1W;
            end
            ST_BMIX1W:
            begin
                hh_next = hh_reg * 64'd5 + 64'h38495ab5;
                buf_next = '0;
                state_next = last_reg ? ST_T2A : ST_IDLE;
            end
            ST_T2A:
            begin
                x_next = buf_reg[127:64];
                y_next = hh_reg;
                state_next = (len_reg[3:0] > 4'd8) ? ST_T2B : ST_T1A;
            end
            ST_T2B: begin mctl.start = 1'b1; mop_b = MM_C2; state_next = ST_T2C; end
            ST_T2C:
            begin
                mop_b = MM_C2;
                if (mdone) begin x_next = rotl64(mp, 6'd33); state_next = ST_T2D; end
            end
            ST_T2D:
            begin
                mctl.start = 1'b1;
                state_next = ST_BMIX2;
            end
            ST_BMIX2:
            begin
                if (mdone)
                begin
                    y_next = hh_reg ^ mp;
                    state_next = ST_T1A;
                end
            end
            ST_T1A:
            begin
                if (len_reg[3:0] > 4'd8) hh_next = y_reg;
                x_next = buf_reg[63:0];
                state_next = (len_reg[3:0] != 4'd0) ? ST_T1B : ST_FIN0;
            end
            ST_T1B: begin mctl.start = 1'b1; state_next = ST_T1C; end
            ST_T1C: if (mdone) begin x_next = rotl64(mp, 6'd31); state_next = ST_T1D; end
            ST_T1D: begin mctl.start = 1'b1; mop_b = MM_C2; state_next = ST_BMIX2W; end
            ST_BMIX2W:
            begin
                mop_b = MM_C2;
                if (mdone) begin hl_next = hl_reg ^ mp; state_next = ST_FIN0; end
            end
            ST_FIN0:
            begin
                // h1 += h2 ; h2 += h1, after length xor
                x_next = (hl_reg ^ 64'(len_reg)) + (hh_reg ^ 64'(len_reg));
                y_next = (hl_reg ^ 64'(len_reg)) + ((hh_reg ^ 64'(len_reg)) << 1);
                state_next = ST_F1A;
            end
            // fmix on x, then on y
            ST_F1A: begin x_next = x_reg ^ (x_reg >> 33); state_next = ST_F1B; end
            ST_F1B: begin mctl.start = 1'b1; mop_b = FMIX_M1; state_next = ST_F1C; end
            ST_F1C:
            begin
                mop_b = FMIX_M1;
                if (mdone) begin x_next = mp ^ (mp >> 33); state_next = ST_F1D; end
            end
            ST_F1D: begin mctl.start = 1'b1; mop_b = FMIX_M2; state_next = ST_F2A; end
            ST_F2A:
            begin
                mop_b = FMIX_M2;
                if (mdone)
                begin
                    hl_next = mp ^ (mp >> 33);
                    x_next = y_reg ^ (y_reg >> 33);
                    state_next = ST_F2B;
                end
            end
            ST_F2B: begin mctl.start = 1'b1; mop_b = FMIX_M1; state_next = ST_F2C; end
            ST_F2C:
            begin
                mop_b = FMIX_M1;
                if (mdone) begin x_next = mp ^ (mp >> 33); state_next = ST_F2D; end
            end
            ST_F2D: begin mctl.start = 1'b1; mop_b = FMIX_M2; state_next = ST_FIN1; end
            ST_FIN1:
            begin
                mop_b = FMIX_M2;
                if (mdone)
                begin
                    // h1 = h1+h2 ; h2 = h2+h1
                    x_next = hl_reg + (mp ^ (mp >> 33));
                    y_next = hl_reg + ((mp ^ (mp >> 33)) << 1);
                    n_next = 6'd0;
                    pres_next = 1'b1;
                    state_next = ST_PROBE;
                end
            end
            ST_PROBE:
            begin
                // x holds h1 + n*h2 running sum
                if ({1'b0, n_reg} >= 7'(probes_eff) || !pres_reg)
                    state_next = ST_RESULT;
                else
                begin
                    dv_next = x_reg;
                    rm_next = '0;
                    bc_next = 7'd0;
                    state_next = ST_PMOD;
                end
            end
            ST_PMOD:
            begin
                // restoring remainder, one bit a cycle
                if (rm_sh >= {1'b0, size_eff})
                    rm_next = SW'(rm_sh - {1'b0, size_eff});
                else
                    rm_next = rm_sh[SW-1:0];
                dv_next = {dv_reg[62:0], 1'b0};
                bc_next = bc_reg + 7'd1;
                if (bc_reg == 7'd63)
                    state_next = ST_PREAD;
            end
            ST_PREAD:
            begin
                if (cmd_reg == CMD_ADD)
                begin
                    ram_we = 1'b1;
                    ram_wd = 1'b1;
                    state_next = ST_PMUL;
                end
                else
                    state_next = ST_PWAIT;
            end
            ST_PWAIT: state_next = ST_PCHK;
            ST_PCHK:
            begin
                if (!ram_rd) pres_next = 1'b0;
                state_next = ST_PMUL;
            end
            ST_PMUL:
            begin
                x_next = x_reg + y_reg;
                n_next = n_reg + 6'd1;
                state_next = ST_PROBE;
            end
            ST_RESULT:
            begin
                ov_next = 1'b1;
                res_next = {(cmd_reg == CMD_QUERY) && pres_reg, cmd_reg};
                hl_next = '0; hh_next = '0; buf_next = '0; len_next = '0;
                state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR;
            hl_reg <= '0; hh_reg <= '0; buf_reg <= '0; len_reg <= '0;
            clr_reg <= '0; ov_reg <= 1'b0; res_reg <= '0;
            cmd_reg <= 1'b0; pres_reg <= 1'b1; last_reg <= 1'b0; n_reg <= '0;
            bc_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            hl_reg <= hl_next; hh_reg <= hh_next; buf_reg <= buf_next;
            len_reg <= len_next; clr_reg <= clr_next; ov_reg <= ov_next;
            res_reg <= res_next; cmd_reg <= cmd_next; pres_reg <= pres_next;
            last_reg <= last_next; n_reg <= n_next; bc_reg <= bc_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        dv_reg <= dv_next;
        rm_reg <= rm_next;
    end

    `BFAQ_IMPLY(a_no_accept_busy, state_reg != ST_IDLE, !s_tready)
    `BFAQ_IMPLY(a_rem_in_range, state_reg == ST_PREAD, rm_reg < size_eff)
    `BFAQ_IMPLY(a_res_add_zero, m_tvalid && !m_tdata[0], !m_tdata[1])
endmodule

// ===== sim/bloom_filter_checker.sv =====
// checker for the bloom filter block: predicts and compares every result item
module bloom_filter_checker #(
    parameter int FILTER_BITS = 65536,
    parameter int MAX_PROBES = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [7:0]  s_tdata,
    input  logic        s_tuser,
    input  logic        s_tlast,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [7:0]  m_tdata,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [16:0] cfg_data,
    output int          fails,
    output int          outstanding,
    output int          hits
);
    import bfaq_pkg::*;

    typedef struct {
        logic was_query;
        logic present;
    } answer_t;

    answer_t     answer_q[$];
    logic [63:0] acc_lo;
    logic [63:0] acc_hi;
    logic [127:0] blk;
    logic [31:0] key_len;
    logic [16:0] size_reg;
    logic [5:0]  probes_reg;
    bit          filter_map [FILTER_BITS];

    function automatic logic [63:0] rot_left(input logic [63:0] x, input int r);
        return (x << r) | (x >> (64 - r));
    endfunction

    function automatic logic [63:0] scramble_lo(input logic [63:0] k);
        k = k * MM_C1;
        k = rot_left(k, 31);
        return k * MM_C2;
    endfunction

    function automatic logic [63:0] scramble_hi(input logic [63:0] k);
        k = k * MM_C2;
        k = rot_left(k, 33);
        return k * MM_C1;
    endfunction

    function automatic logic [63:0] avalanche(input logic [63:0] k);
        k = k ^ (k >> 33);
        k = k * FMIX_M1;
        k = k ^ (k >> 33);
        k = k * FMIX_M2;
        return k ^ (k >> 33);
    endfunction

    // folds one key byte into the hash; on the last byte probes the map
    task automatic hash_byte(input logic cmd, input logic [7:0] b, input logic last);
        logic [3:0]  pos;
        logic [3:0]  tail;
        logic [63:0] h1;
        logic [63:0] h2;
        logic [63:0] modulus;
        logic [63:0] idx;
        int          nprobe;
        logic        present;
        answer_t     ans;
        pos = key_len[3:0];
        blk[pos*8 +: 8] = b;
        key_len = key_len + 1;
        if (pos == 4'd15)
        begin
            acc_lo = acc_lo ^ scramble_lo(blk[63:0]);
            acc_lo = rot_left(acc_lo, 27) + acc_hi;
            acc_lo = acc_lo * 5 + 64'h52dce729;
            acc_hi = acc_hi ^ scramble_hi(blk[127:64]);
            acc_hi = rot_left(acc_hi, 31) + acc_lo;
            acc_hi = acc_hi * 5 + 64'h38495ab5;
            blk = '0;
        end
        if (!last)
            return;
        tail = key_len[3:0];
        h1 = acc_lo;
        h2 = acc_hi;
        if (tail > 8)
            h2 = h2 ^ scramble_hi(blk[127:64]);
        if (tail > 0)
            h1 = h1 ^ scramble_lo(blk[63:0]);
        h1 = h1 ^ {32'd0, key_len};
        h2 = h2 ^ {32'd0, key_len};
        h1 = h1 + h2;
        h2 = h2 + h1;
        h1 = avalanche(h1);
        h2 = avalanche(h2);
        h1 = h1 + h2;
        h2 = h2 + h1;
        modulus = (size_reg == 0 || size_reg > FILTER_BITS) ? FILTER_BITS : size_reg;
        nprobe = (probes_reg > MAX_PROBES) ? MAX_PROBES : probes_reg;
        present = 1'b1;
        for (int n = 0; n < nprobe; n++)
        begin
            idx = (h1 + n * h2) % modulus;
            if (cmd == CMD_QUERY)
            begin
                if (!filter_map[idx])
                begin
                    present = 1'b0;
                    break;
                end
            end
            else
                filter_map[idx] = 1'b1;
        end
        ans.was_query = (cmd == CMD_QUERY);
        ans.present = (cmd == CMD_QUERY) ? present : 1'b0;
        answer_q.push_back(ans);
        acc_lo = '0;
        acc_hi = '0;
        blk = '0;
        key_len = '0;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        answer_t want;
        if (!rst_n)
        begin
            answer_q.delete();
            acc_lo = '0;
            acc_hi = '0;
            blk = '0;
            key_len = '0;
            size_reg = 17'd65536;
            probes_reg = 6'd4;
            foreach (filter_map[i])
                filter_map[i] = 1'b0;
            fails = 0;
            hits = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == CFG_FILTER_SIZE)
                    size_reg = cfg_data;
                else
                    probes_reg = cfg_data[5:0];
            end
            if (s_tvalid && s_tready)
                hash_byte(s_tuser, s_tdata, s_tlast);
            if (m_tvalid && m_tready)
            begin
                if (answer_q.size() == 0)
                begin
                    $display("%0t: unexpected result item, got %h", $time, m_tdata);
                    fails++;
                end
                else
                begin
                    want = answer_q.pop_front();
                    if (m_tdata[0] !== want.was_query)
                    begin
                        $display("%0t: was_query expected %b got %b", $time,
                                 want.was_query, m_tdata[0]);
                        fails++;
                    end
                    if (m_tdata[1] !== want.present)
                    begin
                        $display("%0t: possibly_present expected %b got %b", $time,
                                 want.present, m_tdata[1]);
                        fails++;
                    end
                    if (want.was_query && want.present)
                        hits++;
                end
            end
        end
        outstanding = answer_q.size();
    end
endmodule

// ===== sim/testbench.sv =====
// top of the bloom filter testbench: stimulus, stalls and verdict
module testbench;
    import bfaq_pkg::*;

    localparam int CYCLE_LIMIT = 4000000;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;
    logic        cfg_valid;
    logic        cfg_ready;
    logic        cfg_index;
    logic [16:0] cfg_data;
    int          fails;
    int          outstanding;
    int          hits;
    int          cycles;
    int          bytes_sent;
    int          keys_sent;
    int          burst_left;
    bit          hold_off;

    logic [7:0]  key_store [64][40];
    int          key_lens [64];
    int          stored;

    bloom_filter_add_query dut (.*);

    bloom_filter_checker chk (.*);

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("== FAIL ==");
            $finish;
        end
    end

    // receiver: changing stall patterns, plus one long hold when asked
    initial
    begin
        int mode;
        m_tready = 1'b0;
        forever
        begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(50, 400))
            begin
                @(posedge clk);
                if (hold_off)
                begin
                    m_tready <= 1'b0;
                    repeat (6000) @(posedge clk);
                    hold_off = 1'b0;
                end
                else if (mode == 0)
                    m_tready <= 1'b1;
                else if (mode == 1)
                    m_tready <= ($urandom_range(0, 1) == 1);
                else if (mode == 2)
                    m_tready <= ($urandom_range(0, 7) == 0);
                else
                    m_tready <= ($urandom_range(0, 9) != 0);
            end
        end
    end

    task automatic push_byte(input logic cmd, input logic [7:0] b, input logic last);
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 30);
            if ($urandom_range(0, 2) == 0)
            begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= b;
        s_tuser <= cmd;
        s_tlast <= last;
        do
            @(posedge clk);
        while (!(s_tvalid && s_tready));
        bytes_sent++;
    endtask

    task automatic push_key(input int slot, input logic cmd);
        for (int i = 0; i < key_lens[slot]; i++)
            push_byte(i == key_lens[slot] - 1 ? cmd : logic'($urandom_range(0, 1)),
                      key_store[slot][i], i == key_lens[slot] - 1);
        keys_sent++;
    endtask

    task automatic make_key(input int slot, input int len);
        key_lens[slot] = len;
        for (int i = 0; i < len; i++)
            key_store[slot][i] = $urandom_range(0, 255);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        // idle gap; the block already cleared its hash state with the last result
        repeat (60) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [16:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin
        int          slot;
        logic [16:0] sizes [9];
        logic [16:0] probe_counts [9];
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = CMD_ADD;
        s_tlast = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = CFG_FILTER_SIZE;
        cfg_data = '0;
        cycles = 0;
        bytes_sent = 0;
        keys_sent = 0;
        burst_left = 0;
        hold_off = 1'b0;
        stored = 0;
        sizes = '{17'd1, 17'd17, 17'd0, 17'd131071, 17'd300, 17'd65536,
                  17'd64, 17'd1000, 17'd65535};
        probe_counts = '{17'd1, 17'd3, 17'd63, 17'd32, 17'd0, 17'd2,
                         17'd6, 17'd8, 17'd5};
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: edge bytes, add then query, absent key, tail lengths 8 and 9
        key_lens[0] = 1; key_store[0][0] = 8'h00;
        key_lens[1] = 1; key_store[1][0] = 8'hff;
        push_key(0, CMD_ADD);
        push_key(0, CMD_QUERY);
        push_key(1, CMD_QUERY);
        push_key(1, CMD_ADD);
        make_key(2, 8);
        make_key(3, 9);
        push_key(2, CMD_ADD);
        push_key(3, CMD_QUERY);
        push_key(2, CMD_QUERY);
        drain();
        write_reg(CFG_NUM_HASHES, 17'd0);
        push_key(3, CMD_QUERY);
        drain();
        stored = 4;

        foreach (sizes[p])
        begin
            write_reg(CFG_FILTER_SIZE, sizes[p]);
            write_reg(CFG_NUM_HASHES, probe_counts[p]);
            if (p == 5)
                hold_off = 1'b1;
            while (bytes_sent < 50 + (p + 1) * 180)
            begin
                if ($urandom_range(0, 9) < 4 && stored > 0)
                    // repeat a known key, mostly as a query
                    push_key($urandom_range(0, stored - 1),
                             $urandom_range(0, 3) != 0 ? CMD_QUERY : CMD_ADD);
                else
                begin
                    slot = stored < 64 ? stored : $urandom_range(0, 63);
                    make_key(slot, $urandom_range(0, 9) == 0 ? $urandom_range(17, 40)
                                                              : $urandom_range(1, 18));
                    push_key(slot, logic'($urandom_range(0, 1)));
                    if (stored < 64)
                        stored++;
                end
            end
            drain();
        end

        $display("sent %0d keys in %0d bytes over %0d filter settings", keys_sent,
                 bytes_sent, 11);
        $display("queries answered present: %0d", hits);
        if (fails == 0 && outstanding == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end
endmodule

// ===== sim.f =====
+incdir+hw/rtl
hw/rtl/bfaq_pkg.sv
hw/rtl/bfaq_ram.sv
hw/rtl/bfaq_mul.sv
hw/rtl/bloom_filter_add_query.sv
sim/bloom_filter_checker.sv
sim/testbench.sv
